@@ hw/rtl/dxt_block_texture_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// dxt block texture decoder assertion macros
// shared helpers for concurrent checks on the clock and reset of the module
// ----------------------------------------------------------------------------
`ifndef DXT_BLOCK_TEXTURE_DECODER_DEFINES_SVH
`define DXT_BLOCK_TEXTURE_DECODER_DEFINES_SVH

// same-cycle implication
`define DXTDEC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DXTDEC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/dxtdec_pkg.sv @@
// ----------------------------------------------------------------------------
// dxtdec_pkg
// shared constants, types and arithmetic helpers of the dxt block decoder
// ----------------------------------------------------------------------------
`default_nettype none

package dxtdec_pkg;

   localparam int MaxDim   = 4096;
   localparam int DimW     = $clog2(MaxDim + 1);
   localparam int ColW     = $clog2(MaxDim / 4);
   localparam int CoordW   = $clog2(MaxDim);
   localparam int CsrAddrW = 2;
   localparam int QDepth   = 2;
   localparam int QPtrW    = (QDepth > 1) ? $clog2(QDepth) : 1;
   localparam int QCntW    = $clog2(QDepth + 1);

   localparam logic [CsrAddrW-1:0] CSR_FORMAT = 2'd0;
   localparam logic [CsrAddrW-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CsrAddrW-1:0] CSR_HEIGHT = 2'd2;

   localparam logic [1:0] FMT_DXT1 = 2'd0;
   localparam logic [1:0] FMT_DXT3 = 2'd1;
   localparam logic [1:0] FMT_DXT5 = 2'd2;

   typedef struct packed {
      logic [63:0]     alpha_bits;
      logic [63:0]     color_bits;
      logic [1:0]      fmt;
      logic [ColW-1:0] bx;
      logic [ColW-1:0] by;
      logic [1:0]      last_cx;
      logic [1:0]      last_cy;
      logic            last_img;
   } blk_type;

   typedef logic [7:0] exp5_tab_type [32];
   typedef logic [7:0] exp6_tab_type [64];

   function automatic exp5_tab_type build_exp5();
      exp5_tab_type t;
      for (int i = 0; i < 32; i++) begin
         t[i] = 8'((i * 255) / 31);
      end
      return t;
   endfunction

   function automatic exp6_tab_type build_exp6();
      exp6_tab_type t;
      for (int i = 0; i < 64; i++) begin
         t[i] = 8'((i * 255) / 63);
      end
      return t;
   endfunction

   localparam exp5_tab_type Exp5Tab = build_exp5();
   localparam exp6_tab_type Exp6Tab = build_exp6();

   // x up to 765
   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [20:0] prod;
      prod = 21'(x) * 21'd683;
      return prod[18:11];
   endfunction

   // x up to 1785
   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [24:0] prod;
      prod = 25'(x) * 25'd2341;
      return prod[21:14];
   endfunction

   // x up to 1275
   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [24:0] prod;
      prod = 25'(x) * 25'd3277;
      return prod[21:14];
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dxtdec_front.sv @@
// ----------------------------------------------------------------------------
// dxtdec_front
// config registers, block position counters and block classification
// ----------------------------------------------------------------------------
`default_nettype none

module dxtdec_front
   import dxtdec_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [CsrAddrW-1:0] csr_addr,
   input  wire logic [DimW-1:0]     csr_wdata,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [127:0]        req_tdata,  // alpha_bits, color_bits
   output logic                     push_valid,
   input  wire logic                push_ready,
   output blk_type                  push_data
);

   logic [1:0]      fmt_ff, fmt_in;
   logic [DimW-1:0] width_ff, width_in;
   logic [DimW-1:0] height_ff, height_in;
   logic [ColW-1:0] col_ff, col_in;
   logic [ColW-1:0] row_ff, row_in;

   logic [DimW-1:0] w_eff, h_eff;
   logic [DimW:0]   w_sum, h_sum;
   logic [ColW:0]   cols, rows;
   logic [ColW:0]   col_inc, row_inc;
   logic [DimW-1:0] rem_w, rem_h;
   logic            in_grid;
   logic            accept;

   function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v);
      logic [DimW-1:0] r;
      r = v;
      if (v == '0) r = DimW'(1);
      else if (v > DimW'(MaxDim)) r = DimW'(MaxDim);
      return r;
   endfunction

   always_comb begin
      fmt_in    = fmt_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_FORMAT: fmt_in    = csr_wdata[1:0];
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      w_eff   = eff_dim(width_ff);
      h_eff   = eff_dim(height_ff);
      w_sum   = {1'b0, w_eff} + (DimW+1)'(3);
      h_sum   = {1'b0, h_eff} + (DimW+1)'(3);
      cols    = w_sum[2 +: ColW+1];
      rows    = h_sum[2 +: ColW+1];
      in_grid = ({1'b0, col_ff} < cols) && ({1'b0, row_ff} < rows);
      rem_w   = w_eff - DimW'({col_ff, 2'b00});
      rem_h   = h_eff - DimW'({row_ff, 2'b00});

      req_tready = push_ready;
      accept     = req_tvalid && req_tready;
      push_valid = req_tvalid && in_grid;

      push_data.alpha_bits = req_tdata[63:0];
      push_data.color_bits = req_tdata[127:64];
      push_data.fmt        = fmt_ff;
      push_data.bx         = col_ff;
      push_data.by         = row_ff;
      push_data.last_cx    = (rem_w >= DimW'(4)) ? 2'd3 : 2'(rem_w - DimW'(1));
      push_data.last_cy    = (rem_h >= DimW'(4)) ? 2'd3 : 2'(rem_h - DimW'(1));
      push_data.last_img   = ({1'b0, col_ff} == cols - (ColW+1)'(1)) &&
                             ({1'b0, row_ff} == rows - (ColW+1)'(1));

      col_inc = {1'b0, col_ff} + (ColW+1)'(1);
      row_inc = {1'b0, row_ff} + (ColW+1)'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         if (col_inc >= cols) begin
            col_in = '0;
            row_in = (row_inc >= rows) ? '0 : row_inc[ColW-1:0];
         end else begin
            col_in = col_inc[ColW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_DXT1;
         width_ff  <= DimW'(4);
         height_ff <= DimW'(4);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         fmt_ff    <= fmt_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/dxtdec_queue.sv @@
// ----------------------------------------------------------------------------
// dxtdec_queue
// short register queue of classified blocks between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module dxtdec_queue
   import dxtdec_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire blk_type push_data,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output blk_type      pop_data
);

   blk_type          mem_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   function automatic logic [QPtrW-1:0] ptr_next(input logic [QPtrW-1:0] p);
      return (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
   endfunction

   always_comb begin
      push_ready = (cnt_ff != QCntW'(QDepth));
      pop_valid  = (cnt_ff != '0);
      pop_data   = mem_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;
      wr_ptr_in  = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      cnt_in     = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + QCntW'(1);
      else if (!do_push && do_pop) cnt_in = cnt_ff - QCntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

@@ hw/rtl/dxtdec_back.sv @@
// ----------------------------------------------------------------------------
// dxtdec_back
// builds block color and alpha tables, emits pixels one a cycle unless stalled
// ----------------------------------------------------------------------------
`default_nettype none
`include "dxt_block_texture_decoder_defines.svh"

module dxtdec_back
   import dxtdec_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    pop_valid,
   output logic         pop_ready,
   input  wire blk_type pop_data,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output logic [55:0]  rsp_tdata,  // pixel_rgba, pixel_x, pixel_y
   output logic         rsp_tlast,  // last_of_block
   output logic [0:0]   rsp_tuser   // last_of_image
);

   // table build from queue head
   logic [15:0] c0, c1;
   logic [7:0]  e0 [3];
   logic [7:0]  e1 [3];
   logic [7:0]  c2 [3];
   logic [7:0]  c3 [3];
   logic        four;
   logic [9:0]  s2a, s2b;
   logic [8:0]  s1;
   logic [7:0]  a0, a1;
   logic [7:0]  atab [8];
   logic [23:0] ctab [4];

   // current block
   logic [23:0] ctab_ff [4];
   logic [7:0]  atab_ff [8];
   logic        four_ff;
   logic [31:0] cidx_ff;
   logic [63:0] abits_ff;
   logic [1:0]  fmt_ff;
   logic [ColW-1:0] bx_ff, by_ff;
   logic [1:0]  lcx_ff, lcy_ff;
   logic        limg_ff;
   logic [1:0]  cx_ff, cx_in;
   logic [1:0]  cy_ff, cy_in;
   logic        blk_vld_ff, blk_vld_in;

   // output word
   logic              out_vld_ff, out_vld_in;
   logic [31:0]       out_rgba_ff;
   logic [CoordW-1:0] out_x_ff, out_y_ff;
   logic              out_last_ff, out_img_ff;

   logic        emit, blk_done, load;
   logic [3:0]  p;
   logic [1:0]  ci;
   logic [3:0]  nib;
   logic [47:0] a5bits;
   logic [5:0]  a5off;
   logic [2:0]  ai;
   logic [7:0]  alpha;
   logic        last_px;

   always_comb begin
      c0 = pop_data.color_bits[15:0];
      c1 = pop_data.color_bits[31:16];
      e0[0] = Exp5Tab[c0[15:11]];
      e0[1] = Exp6Tab[c0[10:5]];
      e0[2] = Exp5Tab[c0[4:0]];
      e1[0] = Exp5Tab[c1[15:11]];
      e1[1] = Exp6Tab[c1[10:5]];
      e1[2] = Exp5Tab[c1[4:0]];
      four  = (pop_data.fmt != FMT_DXT1) || (c0 > c1);
      for (int ch = 0; ch < 3; ch++) begin
         s2a = {1'b0, e0[ch], 1'b0} + {2'b00, e1[ch]};
         s2b = {2'b00, e0[ch]} + {1'b0, e1[ch], 1'b0};
         s1  = {1'b0, e0[ch]} + {1'b0, e1[ch]};
         c2[ch] = four ? div3(s2a) : s1[8:1];
         c3[ch] = four ? div3(s2b) : 8'd0;
      end
      ctab[0] = {e0[0], e0[1], e0[2]};
      ctab[1] = {e1[0], e1[1], e1[2]};
      ctab[2] = {c2[0], c2[1], c2[2]};
      ctab[3] = {c3[0], c3[1], c3[2]};

      a0 = pop_data.alpha_bits[7:0];
      a1 = pop_data.alpha_bits[15:8];
      atab[0] = a0;
      atab[1] = a1;
      for (int i = 2; i < 8; i++) atab[i] = 8'd0;
      if (a0 > a1) begin
         for (int i = 1; i <= 6; i++) begin
            atab[i+1] = div7(11'(7 - i) * {3'b000, a0} + 11'(i) * {3'b000, a1});
         end
      end else begin
         for (int i = 1; i <= 4; i++) begin
            atab[i+1] = div5(11'(5 - i) * {3'b000, a0} + 11'(i) * {3'b000, a1});
         end
         atab[6] = 8'd0;
         atab[7] = 8'd255;
      end
   end

   always_comb begin
      p       = {cy_ff, cx_ff};
      ci      = cidx_ff[{p, 1'b0} +: 2];
      nib     = abits_ff[{p, 2'b00} +: 4];
      a5bits  = abits_ff[63:16];
      a5off   = 6'({p, 1'b0}) + 6'(p);
      ai      = a5bits[a5off +: 3];
      unique case (fmt_ff)
         FMT_DXT1: alpha = (ci == 2'd3 && !four_ff) ? 8'd0 : 8'd255;
         FMT_DXT3: alpha = {nib, nib};
         default:  alpha = atab_ff[ai];
      endcase
      last_px = (cx_ff == lcx_ff) && (cy_ff == lcy_ff);

      emit     = blk_vld_ff && (!out_vld_ff || rsp_tready);
      blk_done = emit && last_px;
      load     = pop_valid && (!blk_vld_ff || blk_done);
      pop_ready = !blk_vld_ff || blk_done;

      blk_vld_in = blk_vld_ff;
      if (load) blk_vld_in = 1'b1;
      else if (blk_done) blk_vld_in = 1'b0;

      cx_in = cx_ff;
      cy_in = cy_ff;
      if (load) begin
         cx_in = '0;
         cy_in = '0;
      end else if (emit) begin
         if (cx_ff == lcx_ff) begin
            cx_in = '0;
            cy_in = cy_ff + 2'd1;
         end else begin
            cx_in = cx_ff + 2'd1;
         end
      end

      out_vld_in = out_vld_ff;
      if (emit) out_vld_in = 1'b1;
      else if (rsp_tready) out_vld_in = 1'b0;

      rsp_tvalid   = out_vld_ff;
      rsp_tdata    = {out_y_ff, out_x_ff, out_rgba_ff};
      rsp_tlast    = out_last_ff;
      rsp_tuser[0] = out_img_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         cx_ff      <= '0;
         cy_ff      <= '0;
      end else begin
         blk_vld_ff <= blk_vld_in;
         out_vld_ff <= out_vld_in;
         cx_ff      <= cx_in;
         cy_ff      <= cy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctab_ff  <= ctab;
         atab_ff  <= atab;
         four_ff  <= four;
         cidx_ff  <= pop_data.color_bits[63:32];
         abits_ff <= pop_data.alpha_bits;
         fmt_ff   <= pop_data.fmt;
         bx_ff    <= pop_data.bx;
         by_ff    <= pop_data.by;
         lcx_ff   <= pop_data.last_cx;
         lcy_ff   <= pop_data.last_cy;
         limg_ff  <= pop_data.last_img;
      end
      if (emit) begin
         out_rgba_ff <= {ctab_ff[ci], alpha};
         out_x_ff    <= {bx_ff, cx_ff};
         out_y_ff    <= {by_ff, cy_ff};
         out_last_ff <= last_px;
         out_img_ff  <= last_px && limg_ff;
      end
   end

   `DXTDEC_ASSERT_NOW(a_img_is_blk_end, out_vld_ff && out_img_ff, out_last_ff,
      "last_of_image without last_of_block")
   `DXTDEC_ASSERT_NOW(a_pos_in_block, blk_vld_ff, (cx_ff <= lcx_ff) && (cy_ff <= lcy_ff),
      "pixel position beyond block extent")
   `DXTDEC_ASSERT_NEXT(a_blk_kept, emit && !last_px, blk_vld_ff,
      "block dropped before its last pixel")
   `DXTDEC_ASSERT_NOW(a_load_when_free, load, !blk_vld_ff || blk_done,
      "block loaded over a busy block")

endmodule

`default_nettype wire

@@ hw/rtl/dxt_block_texture_decoder.sv @@
// ----------------------------------------------------------------------------
// dxt_block_texture_decoder
// decodes dxt1 / dxt3 / dxt5 4x4 blocks into cropped rgba8888 pixel words
// a block's first pixel passes the queue entry, block registers and output word register
// throughput: one pixel word per cycle unless rsp_tready stalls, up to 16 words per
//    block from the single pixel emitter; blocks wholly outside the image are dropped
// a 2-entry block queue lets block intake run ahead of pixel output
// reset: synchronous, clears block counters, queue and output; format dxt1, 4x4
// ----------------------------------------------------------------------------
`default_nettype none

module dxt_block_texture_decoder
   import dxtdec_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [CsrAddrW-1:0] csr_addr,
   input  wire logic [DimW-1:0]     csr_wdata,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [127:0]        req_tdata,  // alpha_bits, color_bits
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [55:0]              rsp_tdata,  // pixel_rgba, pixel_x, pixel_y
   output logic                     rsp_tlast,  // last_of_block
   output logic [0:0]               rsp_tuser   // last_of_image
);

   logic    push_valid, push_ready;
   blk_type push_data;
   logic    pop_valid, pop_ready;
   blk_type pop_data;

   dxtdec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   dxtdec_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   dxtdec_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

@@ sim/dxt_block_texture_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxt_block_texture_decoder_tb
// drives compressed 4x4 blocks through the decoder under dxt1, dxt3, dxt5 and
// the spare format code, across cropped, degenerate and oversized image sizes,
// and checks every pixel word against a local decoder with bursty input and
// a stalling output
// ----------------------------------------------------------------------------

module dxt_block_texture_decoder_tb
   import dxtdec_pkg::*;
;

   localparam logic [1:0] FMT_SPARE        = 2'd3;
   localparam int         SETTLE_CYCLES    = 20;
   localparam int         RANDOM_PER_PHASE = 21;
   localparam int         RANDOM_PHASES    = 6;

   typedef struct packed {
      logic [31:0] rgba;
      logic [11:0] x;
      logic [11:0] y;
      logic        last_blk;
      logic        last_img;
   } pixel_word_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_RARELY,
      READY_PERIODIC
   } ready_mode_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                csr_we     = 1'b0;
   logic [CsrAddrW-1:0] csr_addr   = '0;
   logic [DimW-1:0]     csr_wdata  = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [127:0]        req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [55:0]         rsp_tdata;
   logic                rsp_tlast;
   logic [0:0]          rsp_tuser;

   // decoder settings and block position as the checker sees them
   logic [1:0]          cfg_format = FMT_DXT1;
   logic [DimW-1:0]     cfg_width  = 13'd4;
   logic [DimW-1:0]     cfg_height = 13'd4;
   int                  blk_col    = 0;
   int                  blk_row    = 0;

   pixel_word_type      expected_pixels [$];
   pixel_word_type      want;
   int                  mismatch_count = 0;

   ready_mode_type      ready_mode  = READY_ALWAYS;
   logic [6:0]          ready_timer = '0;

   dxt_block_texture_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   function automatic int eff_dim(input logic [DimW-1:0] v);
      if (v == 0) return 1;
      if (v > MaxDim) return MaxDim;
      return int'(v);
   endfunction

   function automatic logic [31:0] pack_rgba(input int r, input int g, input int b, input int a);
      return {r[7:0], g[7:0], b[7:0], a[7:0]};
   endfunction

   function automatic logic [DimW-1:0] pick_dim();
      case ($urandom_range(0, 9))
         0: return 13'd0;
         1: return 13'd1;
         2: return 13'd4096;
         3: return 13'($urandom);
         default: return 13'($urandom_range(2, 20));
      endcase
   endfunction

   // expected pixel words of one block, then the block position moves on
   task automatic decode_block(input logic [63:0] ab, input logic [63:0] cb);
      int             w, h, cols, rows, px, py;
      int             r0, g0, b0, r1, g1, b1, a0, a1;
      logic [15:0]    c0, c1;
      logic [31:0]    ctab [4];
      int             atab [8];
      logic [31:0]    rgba;
      pixel_word_type pix;
      pixel_word_type blk_pixels [$];
      w    = eff_dim(cfg_width);
      h    = eff_dim(cfg_height);
      cols = (w + 3) / 4;
      rows = (h + 3) / 4;
      c0   = cb[15:0];
      c1   = cb[31:16];
      r0   = (int'(c0[15:11]) * 255) / 31;
      g0   = (int'(c0[10:5]) * 255) / 63;
      b0   = (int'(c0[4:0]) * 255) / 31;
      r1   = (int'(c1[15:11]) * 255) / 31;
      g1   = (int'(c1[10:5]) * 255) / 63;
      b1   = (int'(c1[4:0]) * 255) / 31;
      ctab[0] = pack_rgba(r0, g0, b0, 255);
      ctab[1] = pack_rgba(r1, g1, b1, 255);
      if (cfg_format != FMT_DXT1 || c0 > c1) begin
         ctab[2] = pack_rgba((2 * r0 + r1) / 3, (2 * g0 + g1) / 3, (2 * b0 + b1) / 3, 255);
         ctab[3] = pack_rgba((r0 + 2 * r1) / 3, (g0 + 2 * g1) / 3, (b0 + 2 * b1) / 3, 255);
      end else begin
         ctab[2] = pack_rgba((r0 + r1) / 2, (g0 + g1) / 2, (b0 + b1) / 2, 255);
         ctab[3] = '0;
      end
      a0 = int'(ab[7:0]);
      a1 = int'(ab[15:8]);
      atab[0] = a0;
      atab[1] = a1;
      if (a0 > a1) begin
         for (int i = 1; i <= 6; i++) atab[i + 1] = ((7 - i) * a0 + i * a1) / 7;
      end else begin
         for (int i = 1; i <= 4; i++) atab[i + 1] = ((5 - i) * a0 + i * a1) / 5;
         atab[6] = 0;
         atab[7] = 255;
      end
      for (int p = 0; p < 16; p++) begin
         px = blk_col * 4 + p % 4;
         py = blk_row * 4 + p / 4;
         if (px < w && py < h) begin
            rgba = ctab[cb[32 + 2 * p +: 2]];
            if (cfg_format == FMT_DXT3) begin
               rgba[7:0] = 8'(int'(ab[4 * p +: 4]) * 17);
            end else if (cfg_format != FMT_DXT1) begin
               rgba[7:0] = 8'(atab[ab[16 + 3 * p +: 3]]);
            end
            pix.rgba     = rgba;
            pix.x        = px[11:0];
            pix.y        = py[11:0];
            pix.last_blk = 1'b0;
            pix.last_img = (px == w - 1 && py == h - 1);
            blk_pixels.push_back(pix);
         end
      end
      foreach (blk_pixels[i]) begin
         pix          = blk_pixels[i];
         pix.last_blk = (i == blk_pixels.size() - 1);
         expected_pixels.push_back(pix);
      end
      blk_col++;
      if (blk_col >= cols) begin
         blk_col = 0;
         blk_row++;
         if (blk_row >= rows) blk_row = 0;
      end
   endtask

   task automatic send_block(input logic [63:0] ab, input logic [63:0] cb);
      req_tdata  <= {cb, ab};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_block(ab, cb);
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // also covers blocks outside the image that are still in flight
   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [1:0] fmt, input logic [DimW-1:0] w,
                             input logic [DimW-1:0] h);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_FORMAT;
      csr_wdata <= DimW'(fmt);
      @(posedge clock);
      csr_addr  <= CSR_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_addr  <= CSR_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we     <= 1'b0;
      cfg_format = fmt;
      cfg_width  = w;
      cfg_height = h;
   endtask

   // reset settings: four-color, three-color and equal-endpoint blocks
   task automatic test_dxt1_color_modes();
      send_block(64'h0, 64'hE4E4E4E4_0000_FFFF);
      send_block(64'h0, 64'hE4E4E4E4_FFFF_0000);
      send_block(64'h0, 64'hFFFFFFFF_7BEF_7BEF);
      send_block(64'hFFFFFFFF_FFFFFFFF, 64'hFFFFFFFF_FFFFFFFF);
      send_block(64'h0123_4567_89AB_CDEF, 64'h1B1B1B1B_07E0_F800);
      wait_results_done();
   endtask

   task automatic test_dxt3_explicit_alpha();
      set_config(FMT_DXT3, 13'd4, 13'd4);
      send_block(64'h0, 64'hE4E4E4E4_F800_001F);
      send_block(64'hFFFFFFFF_FFFFFFFF, 64'hE4E4E4E4_F800_001F);
      send_block(64'h0123_4567_89AB_CDEF, 64'h39C6_5A5A_07E0_8410);
      wait_results_done();
   endtask

   // eight-entry, six-entry, equal endpoints, then the spare format code
   task automatic test_dxt5_alpha_tables();
      set_config(FMT_DXT5, 13'd4, 13'd4);
      send_block(64'hFAC688FAC688_00FF, 64'hE4E4E4E4_1234_ABCD);
      send_block(64'hFAC688FAC688_FF00, 64'hE4E4E4E4_ABCD_1234);
      send_block(64'hFAC688FAC688_8080, 64'hE4E4E4E4_5555_5555);
      send_block(64'hFFFFFFFF_FFFFFFFF, 64'h0);
      wait_results_done();
      set_config(FMT_SPARE, 13'd4, 13'd4);
      send_block(64'hFAC688FAC688_10F0, 64'h1B1B1B1B_0000_FFFF);
      wait_results_done();
   endtask

   task automatic test_cropping_and_dims();
      set_config(FMT_DXT1, 13'd5, 13'd7);
      repeat (4) send_block({$urandom, $urandom}, {$urandom, $urandom});
      wait_results_done();
      // zero sizes act as one pixel
      set_config(FMT_DXT3, 13'd0, 13'd0);
      repeat (2) send_block({$urandom, $urandom}, {$urandom, $urandom});
      wait_results_done();
      // oversized clamps to the largest image
      set_config(FMT_DXT5, 13'd8191, 13'd4097);
      repeat (2) send_block({$urandom, $urandom}, {$urandom, $urandom});
      wait_results_done();
      // position now lies outside the shrunken grid
      set_config(FMT_DXT1, 13'd4, 13'd4);
      repeat (2) send_block({$urandom, $urandom}, {$urandom, $urandom});
      wait_results_done();
   endtask

   task automatic test_random_images();
      int          burst_left;
      bit          bursty;
      logic [15:0] c0, c1;
      logic [63:0] ab, cb;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_config(2'($urandom_range(0, 3)), pick_dim(), pick_dim());
         bursty     = (phase % 3 != 0);
         burst_left = $urandom_range(1, 10);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            c0 = 16'($urandom);
            c1 = ($urandom_range(0, 3) == 0) ? c0 : 16'($urandom);
            cb = {$urandom, c1, c0};
            ab = {$urandom, $urandom};
            if ($urandom_range(0, 3) == 0) ab[15:8] = ab[7:0];
            if (phase == 2 && n == RANDOM_PER_PHASE / 2) wait_results_done();
            send_block(ab, cb);
            if (bursty) begin
               burst_left--;
               if (burst_left == 0) begin
                  idle_sender($urandom_range(1, 6));
                  burst_left = $urandom_range(1, 10);
               end
            end
         end
         wait_results_done();
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s expected %h actual %h", $time, name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   // output stall pattern
   always @(posedge clock) begin
      if (ready_timer == 0) begin
         ready_mode  <= ready_mode_type'($urandom_range(0, 3));
         ready_timer <= 7'($urandom_range(16, 80));
      end else begin
         ready_timer <= ready_timer - 1'b1;
      end
      case (ready_mode)
         READY_ALWAYS:  rsp_tready <= 1'b1;
         READY_MOSTLY:  rsp_tready <= ($urandom_range(0, 3) != 0);
         READY_RARELY:  rsp_tready <= ($urandom_range(0, 2) == 0);
         default:       rsp_tready <= (ready_timer[1:0] != 2'b00);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: pixel word with none expected, actual %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_pixels.pop_front();
            compare_field("pixel_rgba", want.rgba, rsp_tdata[31:0]);
            compare_field("pixel_x", 32'(want.x), 32'(rsp_tdata[43:32]));
            compare_field("pixel_y", 32'(want.y), 32'(rsp_tdata[55:44]));
            compare_field("last_of_block", 32'(want.last_blk), 32'(rsp_tlast));
            compare_field("last_of_image", 32'(want.last_img), 32'(rsp_tuser[0]));
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_dxt1_color_modes();
      test_dxt3_explicit_alpha();
      test_dxt5_alpha_tables();
      test_cropping_and_dims();
      test_random_images();
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
